[sv/ffa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit allocator
// Request and response word layouts, status codes and command structs.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic CFG_HEAP_BASE = 1'b0;
	localparam logic CFG_HEAP_SIZE = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] alloc_size;
		logic [7:0]  align_bytes;
		logic [31:0] free_address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted_address;
		logic [31:0] bytes_used;
		logic [6:0]  live_allocations;
	} rsp_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic init;       // reinitialize tables and counters
		logic load;       // capture request word
		logic clr_idx;    // index counters to zero
		logic rec_step;   // advance record scan
		logic seg_step;   // advance segment scan
		logic alloc_do;   // apply allocation
		logic free_do;    // apply free (merge or start insert)
		logic shift_step; // one entry of a table shift
		logic finish;     // build response
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic is_free;
		logic rec_done;   // record scan ended
		logic rec_hit;    // free slot / matching record found
		logic seg_done;   // segment scan ended
		logic seg_hit;    // fitting segment / insert point found
		logic can_apply;  // free fits in segment table
		logic shift_done;
	} sts_t;

endpackage

[sv/ffa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ctrl: request sequencer
// Steps a request through record scan, segment scan, update and shifting.
// ----------------------------------------------------------------------------
module ffa_ctrl
	import ffa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  logic cfg_we,
	input  sts_t sts,
	output cmd_t cmd,
	output logic fail_q
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_REC   = 7'b0000010,
		S_SEG   = 7'b0000100,
		S_APPLY = 7'b0001000,
		S_SHIFT = 7'b0010000,
		S_DONE  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic   fail_d;

	always_comb begin
		cmd = '0;
		cmd.init = cfg_we;
		fail_d = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				cmd.clr_idx = in_valid;
			end
			S_REC: begin
				cmd.rec_step = !sts.rec_done;
				if (sts.rec_done && !sts.rec_hit) fail_d = 1'b1;
			end
			S_SEG: begin
				cmd.seg_step = !sts.seg_done;
				if (sts.seg_done && !sts.is_free && !sts.seg_hit) fail_d = 1'b1;
			end
			S_APPLY: begin
				if (sts.is_free && !sts.can_apply) fail_d = 1'b1;
				else begin
					cmd.alloc_do = !sts.is_free;
					cmd.free_do = sts.is_free;
				end
			end
			S_SHIFT: cmd.shift_step = !sts.shift_done;
			S_DONE: cmd.finish = 1'b1;
			S_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fail_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_REC;
					fail_q <= 1'b0;
				end
				S_REC: if (sts.rec_done) begin
					if (fail_d) begin
						fail_q <= 1'b1;
						state_q <= S_DONE;
					end else state_q <= S_SEG;
				end
				S_SEG: if (sts.seg_done) begin
					if (fail_d) begin
						fail_q <= 1'b1;
						state_q <= S_DONE;
					end else state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (fail_d) begin
						fail_q <= 1'b1;
						state_q <= S_DONE;
					end else state_q <= S_SHIFT;
				end
				S_SHIFT: if (sts.shift_done) state_q <= S_DONE;
				S_DONE: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

endmodule

[sv/ffa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_dp: allocator datapath
// Segment and record tables, scan counters, fit and merge arithmetic.
// ----------------------------------------------------------------------------
module ffa_dp
	import ffa_pkg::*;
#(
	parameter int MAX_FREE_SEGMENTS = 32,
	parameter int MAX_ALLOCATIONS = 64,
	parameter int HEADER_BYTES = 16,
	parameter int NODE_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  req_t        req,
	input  cmd_t        cmd,
	input  logic        fail,
	output sts_t        sts,
	output rsp_t        rsp
);

	localparam int SW = $clog2(MAX_FREE_SEGMENTS);
	localparam int RW = $clog2(MAX_ALLOCATIONS);
	localparam int SCW = $clog2(MAX_FREE_SEGMENTS + 1);
	localparam int RCW = $clog2(MAX_ALLOCATIONS + 1);

	logic [31:0] seg_off_q [MAX_FREE_SEGMENTS];
	logic [31:0] seg_len_q [MAX_FREE_SEGMENTS];
	logic [SCW-1:0] seg_cnt_q;
	logic [31:0] rec_addr_q [MAX_ALLOCATIONS];
	logic [7:0]  rec_hdr_q [MAX_ALLOCATIONS];
	logic [31:0] rec_len_q [MAX_ALLOCATIONS];
	logic [MAX_ALLOCATIONS-1:0] rec_vld_q;
	logic [31:0] used_q;
	logic [RCW-1:0] alloc_cnt_q;
	logic [31:0] base_q, size_q;

	req_t        req_q;
	logic [RCW-1:0] ri_q;
	logic [SCW-1:0] si_q;
	logic [SCW-1:0] sh_q;     // shift cursor
	logic        sh_up_q;     // insertion (move up) vs removal (move down)
	logic [SCW-1:0] sh_end_q;
	logic [32:0] start_q, len_q; // extent of the freed block
	logic [1:0]  status_q;
	logic [31:0] grant_q;
	rsp_t        rsp_q;

	// Registered read of the record table; always holds the entry at ri_q.
	logic [31:0] rec_rd_addr_q;
	logic [7:0]  rec_rd_hdr_q;
	logic [31:0] rec_rd_len_q;

	// Effective alignment mask: highest power of two not above align.
	logic [7:0] amask;
	always_comb begin
		amask = 8'd0;
		for (int b = 7; b >= 0; b--)
			if (req_q.align_bytes[b] && amask == 8'd0) amask = 8'((1 << b) - 1);
	end

	logic [RW-1:0] ri;
	logic [SW-1:0] si;
	assign ri = ri_q[RW-1:0];
	assign si = si_q[SW-1:0];

	// Read address follows the scan index one step ahead.
	logic [RW-1:0] rd_idx;
	assign rd_idx = cmd.clr_idx ? '0 : (cmd.rec_step ? RW'(ri_q + 1'b1) : ri);

	// Fit test of the current segment.
	logic [32:0] x;
	logic [32:0] adj, need;
	assign x = {1'b0, seg_off_q[si]} + 33'(HEADER_BYTES);
	assign adj = 33'(HEADER_BYTES) + 33'((-x) & {25'd0, amask});
	assign need = adj + {1'b0, req_q.alloc_size};
	logic fits;
	assign fits = need <= {1'b0, seg_len_q[si]};

	logic rec_done, seg_done;
	assign rec_done = (ri_q == RCW'(MAX_ALLOCATIONS)) ||
		(req_q.req_type == REQ_ALLOC ? !rec_vld_q[ri]
			: (rec_vld_q[ri] && rec_rd_addr_q == req_q.free_address));
	assign seg_done = (si_q >= seg_cnt_q) ||
		(req_q.req_type == REQ_ALLOC ? fits : ({1'b0, seg_off_q[si]} > start_q));

	// Neighbors for free.
	logic [SW-1:0] sl;
	assign sl = SW'(si_q - 1'b1);
	logic right, left;
	assign right = (si_q < seg_cnt_q) && (start_q + len_q == {1'b0, seg_off_q[si]});
	assign left = (si_q != '0) && ({1'b0, seg_off_q[sl]} + {1'b0, seg_len_q[sl]} == start_q);

	logic [32:0] room, hl;
	assign room = 33'h1_0000_0000 - {1'b0, base_q};

	// Heap length after a register write, clipped at the top of the address space.
	always_comb begin
		if (cfg_index == CFG_HEAP_BASE) begin
			hl = ({1'b0, size_q} > (33'h1_0000_0000 - {1'b0, cfg_data}))
				? (33'h1_0000_0000 - {1'b0, cfg_data}) : {1'b0, size_q};
		end else begin
			hl = ({1'b0, cfg_data} > room) ? room : {1'b0, cfg_data};
		end
	end

	assign sts.is_free = (req_q.req_type == REQ_FREE);
	assign sts.rec_done = rec_done;
	assign sts.rec_hit = (ri_q != RCW'(MAX_ALLOCATIONS));
	assign sts.seg_done = seg_done;
	assign sts.seg_hit = (si_q < seg_cnt_q);
	assign sts.can_apply = right || left || (seg_cnt_q < SCW'(MAX_FREE_SEGMENTS));
	assign sts.shift_done = sh_up_q ? (sh_q <= sh_end_q) : (sh_q + 1'b1 >= sh_end_q);

	logic [SW-1:0] shi, shm;
	assign shi = sh_q[SW-1:0];
	assign shm = SW'(sh_up_q ? sh_q - 1'b1 : sh_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_vld_q <= '0;
			seg_cnt_q <= SCW'(1);
			used_q <= '0;
			alloc_cnt_q <= '0;
			base_q <= 32'd0;
			size_q <= 32'd65536;
			seg_off_q[0] <= 32'd0;
			seg_len_q[0] <= 32'd65536;
		end else if (cmd.init) begin
			if (cfg_index == CFG_HEAP_BASE) begin
				base_q <= cfg_data;
				seg_off_q[0] <= cfg_data;
			end else begin
				size_q <= cfg_data;
				seg_off_q[0] <= base_q;
			end
			seg_len_q[0] <= hl[31:0];
			seg_cnt_q <= (hl == '0) ? '0 : SCW'(1);
			rec_vld_q <= '0;
			used_q <= '0;
			alloc_cnt_q <= '0;
		end else begin
			if (cmd.alloc_do) begin
				rec_addr_q[ri] <= seg_off_q[si] + adj[31:0];
				rec_hdr_q[ri] <= adj[7:0];
				rec_vld_q[ri] <= 1'b1;
				alloc_cnt_q <= alloc_cnt_q + 1'b1;
				if ({1'b0, seg_len_q[si]} - need >= 33'(NODE_BYTES)) begin
					seg_off_q[si] <= seg_off_q[si] + need[31:0];
					seg_len_q[si] <= seg_len_q[si] - need[31:0];
					rec_len_q[ri] <= need[31:0];
					used_q <= used_q + need[31:0];
				end else begin
					rec_len_q[ri] <= seg_len_q[si];
					used_q <= used_q + seg_len_q[si];
					seg_cnt_q <= seg_cnt_q - 1'b1;
				end
			end
			if (cmd.free_do) begin
				rec_vld_q[ri] <= 1'b0;
				used_q <= used_q - len_q[31:0];
				if (alloc_cnt_q != '0) alloc_cnt_q <= alloc_cnt_q - 1'b1;
				if (left && right) begin
					seg_len_q[sl] <= seg_len_q[sl] + len_q[31:0] + seg_len_q[si];
					seg_cnt_q <= seg_cnt_q - 1'b1;
				end else if (left) begin
					seg_len_q[sl] <= seg_len_q[sl] + len_q[31:0];
				end else if (right) begin
					seg_off_q[si] <= start_q[31:0];
					seg_len_q[si] <= seg_len_q[si] + len_q[31:0];
				end else begin
					seg_cnt_q <= seg_cnt_q + 1'b1;
				end
			end
			if (cmd.shift_step) begin
				seg_off_q[shi] <= seg_off_q[shm];
				seg_len_q[shi] <= seg_len_q[shm];
			end
			// A free that merged with nothing drops its extent into the opened slot.
			if (cmd.finish && !fail && sts.is_free && sh_up_q) begin
				seg_off_q[si] <= start_q[31:0];
				seg_len_q[si] <= len_q[31:0];
			end
		end
	end

	// Scan counters, shift setup and response.
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.clr_idx) begin
			ri_q <= '0;
			si_q <= '0;
		end
		rec_rd_addr_q <= rec_addr_q[rd_idx];
		rec_rd_hdr_q <= rec_hdr_q[rd_idx];
		rec_rd_len_q <= rec_len_q[rd_idx];
		if (cmd.rec_step) ri_q <= ri_q + 1'b1;
		if (cmd.rec_step == 1'b0 && rec_done && ri_q != RCW'(MAX_ALLOCATIONS)) begin
			start_q <= {1'b0, rec_rd_addr_q} - {25'd0, rec_rd_hdr_q};
			len_q <= {1'b0, rec_rd_len_q};
		end
		if (cmd.seg_step) si_q <= si_q + 1'b1;
		if (cmd.alloc_do) begin
			grant_q <= seg_off_q[si] + adj[31:0];
			// Whole grant removes entry si: move later entries down.
			sh_up_q <= 1'b0;
			sh_q <= si_q;
			sh_end_q <= ({1'b0, seg_len_q[si]} - need >= 33'(NODE_BYTES)) ? '0 : seg_cnt_q;
		end
		if (cmd.free_do) begin
			if (left && right) begin
				sh_up_q <= 1'b0;
				sh_q <= si_q;
				sh_end_q <= seg_cnt_q;
			end else if (!left && !right) begin
				sh_up_q <= 1'b1;
				sh_q <= seg_cnt_q;
				sh_end_q <= si_q;
			end else begin
				sh_up_q <= 1'b0;
				sh_q <= si_q;
				sh_end_q <= '0;
			end
		end
		if (cmd.shift_step) sh_q <= sh_up_q ? sh_q - 1'b1 : sh_q + 1'b1;
		if (cmd.finish) begin
			rsp_q.status <= !fail ? ST_OK
				: (!sts.rec_hit ? (sts.is_free ? ST_UNKNOWN : ST_FULL)
				: (sts.is_free ? ST_FULL : ST_NOFIT));
			rsp_q.granted_address <= (!fail && !sts.is_free) ? grant_q : 32'd0;
			rsp_q.bytes_used <= used_q;
			rsp_q.live_allocations <= 7'(alloc_cnt_q);
		end
	end

	assign rsp = rsp_q;

endmodule

[sv/first_fit_free_list_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator: first-fit heap allocator with coalescing
// Keeps an address-sorted free-segment table and an allocation record table.
// ----------------------------------------------------------------------------
// Usage: a request word enters on in_valid/in_ready. An allocate request
// takes the first free segment that fits size plus an aligned header; a free
// request returns an extent and merges it with its neighbors. Exactly one
// response word leaves on out_valid/out_ready per request.
// Sequence: one request is handled at a time. It scans the record table,
// then the segment table, applies the update, then shifts segment entries
// one per cycle for insertion or removal, and last builds the response word
// offered on out_valid. After delivery, in_ready returns in the cycle after.
// Reset: one free segment of 64 KiB at address zero, no live allocations.
// Writing heap_base or heap_size reinitializes the tables.
// A stalled receiver holds the response word; no new request is taken until
// it is delivered.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator
	import ffa_pkg::*;
#(
	parameter int MAX_FREE_SEGMENTS = 32,
	parameter int MAX_ALLOCATIONS = 64,
	parameter int HEADER_BYTES = 16,
	parameter int NODE_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic fail;

	ffa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cfg_we(cfg_we), .sts(sts), .cmd(cmd), .fail_q(fail)
	);

	ffa_dp #(
		.MAX_FREE_SEGMENTS(MAX_FREE_SEGMENTS), .MAX_ALLOCATIONS(MAX_ALLOCATIONS),
		.HEADER_BYTES(HEADER_BYTES), .NODE_BYTES(NODE_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req(in_data), .cmd(cmd), .fail(fail), .sts(sts), .rsp(out_data)
	);

endmodule

[sv/ffa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_checker: port-level checks of the allocator
// Watches the handshakes and the response word over time.
// ----------------------------------------------------------------------------
module ffa_checker
	import ffa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input rsp_t out_data
);

	// One request at a time: no new word accepted while a response waits.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while response pending");

	// A stalled response word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response changed while stalled");

	// A failed request grants no address.
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.granted_address == 32'd0)
		else $error("address granted on failure");

	// Live allocation count never exceeds its range.
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.live_allocations <= 7'd64)
		else $error("live allocation count out of range");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[verif/first_fit_free_list_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_tb: self-checking bench for the allocator
// Drives allocate and free requests under random idling on both sides,
// predicts every response word with a local allocator model and compares.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_tb;
	import ffa_pkg::*;

	localparam int SEGS = 32;
	localparam int RECS = 64;
	localparam int HDR = 16;
	localparam int NODE = 16;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	always #5 clk = ~clk;

	first_fit_free_list_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: a mirror of the allocator's tables.
	logic [31:0] m_base, m_size;
	logic [31:0] m_seg_off[SEGS];
	logic [31:0] m_seg_len[SEGS];
	int m_seg_cnt;
	logic [31:0] m_rec_addr[RECS];
	logic [7:0] m_rec_hdr[RECS];
	logic [31:0] m_rec_len[RECS];
	bit m_rec_live[RECS];
	logic [31:0] m_used;
	int m_live;

	rsp_t expected_rsp[$];
	// Addresses handed out and not yet freed, used to build legal frees.
	logic [31:0] live_addrs[$];

	int mismatches = 0;
	bit timed_out = 1'b0;
	bit hold_off = 1'b0;
	bit stall_enable = 1'b1;
	longint cycle_count = 0;

	function automatic void heap_reinit();
		logic [32:0] room;
		logic [32:0] len;
		room = 33'h1_0000_0000 - {1'b0, m_base};
		len = {1'b0, m_size};
		if (len > room) len = room;
		for (int i = 0; i < SEGS; i++) begin
			m_seg_off[i] = '0;
			m_seg_len[i] = '0;
		end
		for (int i = 0; i < RECS; i++) m_rec_live[i] = 1'b0;
		m_seg_off[0] = m_base;
		m_seg_len[0] = len[31:0];
		m_seg_cnt = (len == 0) ? 0 : 1;
		m_used = '0;
		m_live = 0;
		live_addrs.delete();
	endfunction

	// Header offset: at least HDR bytes, padded so that the payload is aligned.
	function automatic logic [32:0] hdr_pad(logic [31:0] addr, logic [7:0] align);
		logic [32:0] p, x, mask;
		p = 1;
		if (align != 0)
			while ((p << 1) <= align) p = p << 1;
		mask = p - 1;
		x = {1'b0, addr} + HDR;
		return HDR + ((33'd0 - x) & mask);
	endfunction

	function automatic rsp_t heap_predict(req_t rq);
		rsp_t r;
		int slot, i, k;
		logic [33:0] adj, total, rem, start, len;
		bit right, left;
		r = '0;
		r.status = ST_OK;
		if (rq.req_type == REQ_ALLOC) begin
			slot = RECS;
			for (i = 0; i < RECS; i++)
				if (!m_rec_live[i]) begin
					slot = i;
					break;
				end
			if (slot == RECS) r.status = ST_FULL;
			else begin
				adj = 0;
				for (i = 0; i < m_seg_cnt; i++) begin
					adj = hdr_pad(m_seg_off[i], rq.align_bytes);
					if (adj + rq.alloc_size <= m_seg_len[i]) break;
				end
				if (i >= m_seg_cnt) r.status = ST_NOFIT;
				else begin
					total = adj + rq.alloc_size;
					rem = m_seg_len[i] - total;
					m_rec_addr[slot] = m_seg_off[i] + adj[31:0];
					m_rec_hdr[slot] = adj[7:0];
					if (rem >= NODE) begin
						m_seg_off[i] = m_seg_off[i] + total[31:0];
						m_seg_len[i] = rem[31:0];
					end else begin
						total = m_seg_len[i];
						for (k = i; k + 1 < m_seg_cnt; k++) begin
							m_seg_off[k] = m_seg_off[k + 1];
							m_seg_len[k] = m_seg_len[k + 1];
						end
						m_seg_cnt--;
					end
					m_rec_len[slot] = total[31:0];
					m_rec_live[slot] = 1'b1;
					m_used = m_used + total[31:0];
					m_live++;
					r.granted_address = m_rec_addr[slot];
					live_addrs.push_back(m_rec_addr[slot]);
				end
			end
		end else begin
			slot = RECS;
			for (i = 0; i < RECS; i++)
				if (m_rec_live[i] && m_rec_addr[i] == rq.free_address) begin
					slot = i;
					break;
				end
			if (slot == RECS) r.status = ST_UNKNOWN;
			else begin
				start = rq.free_address - m_rec_hdr[slot];
				len = m_rec_len[slot];
				for (i = 0; i < m_seg_cnt; i++)
					if (m_seg_off[i] > start) break;
				right = (i < m_seg_cnt) && (start + len == m_seg_off[i]);
				left = (i > 0) && ({2'b0, m_seg_off[i-1]} + m_seg_len[i-1] == start);
				if (!right && !left && m_seg_cnt >= SEGS) r.status = ST_FULL;
				else begin
					if (left && right) begin
						m_seg_len[i-1] = m_seg_len[i-1] + len[31:0] + m_seg_len[i];
						for (k = i; k + 1 < m_seg_cnt; k++) begin
							m_seg_off[k] = m_seg_off[k + 1];
							m_seg_len[k] = m_seg_len[k + 1];
						end
						m_seg_cnt--;
					end else if (left) begin
						m_seg_len[i-1] = m_seg_len[i-1] + len[31:0];
					end else if (right) begin
						m_seg_off[i] = start[31:0];
						m_seg_len[i] = m_seg_len[i] + len[31:0];
					end else begin
						for (k = m_seg_cnt; k > i; k--) begin
							m_seg_off[k] = m_seg_off[k - 1];
							m_seg_len[k] = m_seg_len[k - 1];
						end
						m_seg_off[i] = start[31:0];
						m_seg_len[i] = len[31:0];
						m_seg_cnt++;
					end
					m_rec_live[slot] = 1'b0;
					m_used = m_used - len[31:0];
					if (m_live > 0) m_live--;
					foreach (live_addrs[j])
						if (live_addrs[j] == rq.free_address) begin
							live_addrs.delete(j);
							break;
						end
				end
			end
		end
		r.bytes_used = m_used;
		r.live_allocations = m_live[6:0];
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// The leading edge keeps the drop of valid and the next offer apart.
	task automatic send_word(req_t rq);
		int g;
		g = gap_len();
		repeat (g + 1) @(posedge clk);
		expected_rsp.push_back(heap_predict(rq));
		in_valid <= 1'b1;
		in_data <= rq;
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_rsp.size() != 0) @(posedge clk);
		// Allow the block's worst-case walk to wind down before idle writes.
		repeat (150) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HEAP_BASE) m_base = val;
		else m_size = val;
		heap_reinit();
		@(posedge clk);
	endtask

	function automatic req_t alloc_word(logic [31:0] sz, logic [7:0] al);
		req_t rq;
		rq = '0;
		rq.req_type = REQ_ALLOC;
		rq.alloc_size = sz;
		rq.align_bytes = al;
		rq.free_address = $urandom();
		return rq;
	endfunction

	function automatic req_t free_word(logic [31:0] a);
		req_t rq;
		rq.req_type = REQ_FREE;
		rq.alloc_size = $urandom();
		rq.align_bytes = 8'($urandom());
		rq.free_address = a;
		return rq;
	endfunction

	function automatic logic [7:0] rand_align();
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
		return 8'd1 << $urandom_range(0, 7);
	endfunction

	function automatic logic [31:0] pick_live();
		return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
	endfunction

	// Extremes of every field, both operations and each corner case.
	task automatic test_directed();
		send_word(alloc_word(32'd0, 8'd1));
		send_word(alloc_word(32'd100, 8'd128));
		send_word(alloc_word(32'd7, 8'd0));           // zero alignment acts as one
		send_word(alloc_word(32'd33, 8'd100));        // non power of two rounds down
		send_word(alloc_word(32'hFFFF_FFFF, 8'd255)); // nothing fits
		send_word(free_word(32'h1234_5679));          // unknown address
		send_word(free_word(pick_live()));
		send_word(free_word(pick_live()));
		send_word(free_word(pick_live()));
		send_word(free_word(pick_live()));            // merges back to one segment
		// Exact fit leaves a tail too small for a node: whole segment granted.
		send_word(alloc_word(32'd65536 - 16 - 8, 8'd1));
		send_word(free_word(pick_live()));
		drain();
		// Heap clipped at the top of the address space.
		cfg_write(CFG_HEAP_BASE, 32'hFFFF_FF00);
		cfg_write(CFG_HEAP_SIZE, 32'hFFFF_FFFF);
		send_word(alloc_word(32'd64, 8'd64));
		send_word(alloc_word(32'd200, 8'd1));
		send_word(free_word(pick_live()));
		drain();
		// Empty heap: every allocate fails.
		cfg_write(CFG_HEAP_SIZE, 32'd0);
		send_word(alloc_word(32'd1, 8'd1));
		drain();
		cfg_write(CFG_HEAP_BASE, 32'd0);
		cfg_write(CFG_HEAP_SIZE, 32'd16);
		send_word(alloc_word(32'd0, 8'd1));
		send_word(alloc_word(32'd0, 8'd1));
		drain();
	endtask

	// Fill the record table, then hit it once more.
	task automatic test_record_full();
		cfg_write(CFG_HEAP_BASE, 32'h0000_1000);
		cfg_write(CFG_HEAP_SIZE, 32'd65536);
		for (int i = 0; i < RECS; i++) send_word(alloc_word($urandom_range(1, 40), 8'd4));
		send_word(alloc_word(32'd1, 8'd1));
		drain();
	endtask

	// Fragment the free table until a non-merging free is refused.
	task automatic test_segment_full();
		logic [31:0] addrs[$];
		cfg_write(CFG_HEAP_SIZE, 32'd65536);
		for (int i = 0; i < RECS; i++) begin
			send_word(alloc_word(32'd16, 8'd1));
			addrs.push_back(live_addrs[$]);
		end
		for (int i = 0; i < RECS; i += 2) send_word(free_word(addrs[i]));
		send_word(free_word(addrs[RECS - 1]));
		drain();
	endtask

	// The receiver holds off while requests keep arriving, so input stalls.
	task automatic test_backpressure();
		cfg_write(CFG_HEAP_SIZE, 32'd65536);
		hold_off = 1'b1;
		for (int i = 0; i < 20; i++) send_word(alloc_word($urandom_range(1, 300), rand_align()));
		hold_off = 1'b0;
		drain();
	endtask

	task automatic test_random(int count);
		int p;
		req_t rq;
		for (int n = 0; n < count; n++) begin
			if (n % 250 == 249) begin
				drain();
				if ($urandom_range(0, 1)) cfg_write(CFG_HEAP_BASE, $urandom());
				else cfg_write(CFG_HEAP_SIZE, $urandom_range(16, 200000));
			end
			if (n % 100 == 50) stall_enable = ~stall_enable;
			p = $urandom_range(0, 99);
			if (p < 5) begin
				rq = alloc_word($urandom(), 8'($urandom()));
			end else if (p < 10) begin
				rq = free_word($urandom());
			end else if (p < 55 || live_addrs.size() == 0) begin
				rq = alloc_word($urandom_range(0, 2000), rand_align());
			end else begin
				rq = free_word(pick_live());
			end
			send_word(rq);
		end
		drain();
	endtask

	// Receiver: random stalls, plus a long hold-off counted in cycles.
	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			g = stall_enable ? gap_len() : 0;
			if (g != 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Response checker: compare each accepted word with the oldest prediction.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %p", out_data);
			end else begin
				e = expected_rsp.pop_front();
				if (out_data !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, out_data);
				end
			end
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		m_base = 32'd0;
		m_size = 32'd65536;
		heap_reinit();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_record_full();
		test_segment_full();
		test_backpressure();
		test_random(600);
		if (expected_rsp.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
